/* design/bmcm_pkg.sv */
package bmcm_pkg;

	localparam int PIX_W    = 8;
	localparam int COUNT_W  = 23;
	localparam int FRAC_BITS = 16;
	localparam int RATE_W   = FRAC_BITS + 1;
	// sums of up to four counts
	localparam int SUM_W    = COUNT_W + 2;
	localparam int STEP_W   = 5;
	localparam int CFG_IDX_W = 8;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = 1;
	localparam int QCNT_W   = 2;
	localparam int RATE_NUM = 7;

	localparam logic [COUNT_W-1:0] MAX_PIXELS = COUNT_W'(4194304);
	localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(FRAC_BITS);

	localparam logic [CFG_IDX_W-1:0] REG_RESULT_THR = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TRUTH_THR  = CFG_IDX_W'(1);

	localparam logic [PIX_W-1:0] RESULT_THR_RST = PIX_W'(0);
	localparam logic [PIX_W-1:0] TRUTH_THR_RST  = PIX_W'(3);

	typedef struct packed {
		logic [PIX_W-1:0] result_pixel;
		logic [PIX_W-1:0] truth_pixel;
		logic             last_pixel;
	} in_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] true_pos;
		logic [COUNT_W-1:0] true_neg;
		logic [COUNT_W-1:0] false_pos;
		logic [COUNT_W-1:0] false_neg;
		logic [RATE_W-1:0]  sensitivity;
		logic [RATE_W-1:0]  specificity;
		logic [RATE_W-1:0]  false_pos_rate;
		logic [RATE_W-1:0]  false_neg_rate;
		logic [RATE_W-1:0]  pos_pred_value;
		logic [RATE_W-1:0]  neg_pred_value;
		logic [RATE_W-1:0]  accuracy;
	} out_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] tp;
		logic [COUNT_W-1:0] tn;
		logic [COUNT_W-1:0] fp;
		logic [COUNT_W-1:0] fn;
	} counts_t;

	typedef enum logic [2:0] {
		R_SENS,
		R_SPEC,
		R_FPR,
		R_FNR,
		R_PPV,
		R_NPV,
		R_ACC
	} rate_sel_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_OUT
	} back_state_t;

	function automatic logic [COUNT_W-1:0] sat_bump(input logic [COUNT_W-1:0] c);
		logic [COUNT_W-1:0] r;
		r = (c < MAX_PIXELS) ? c + COUNT_W'(1) : c;
		return r;
	endfunction

endpackage

/* design/bmcm_front.sv */
module bmcm_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  bmcm_pkg::in_item_t                  in_item,
	input  logic                                q_full,
	output logic                                q_push,
	output bmcm_pkg::counts_t                   q_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bmcm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bmcm_pkg::PIX_W-1:0]          cfg_data
);

	logic [bmcm_pkg::PIX_W-1:0] res_thr_q;
	logic [bmcm_pkg::PIX_W-1:0] tru_thr_q;
	bmcm_pkg::counts_t          cnt_q;
	bmcm_pkg::counts_t          cnt_inc;
	logic                       res_pos;
	logic                       tru_pos;
	logic                       accept;

	assign cfg_ready = 1'b1;
	assign accept    = push && !q_full;
	assign res_pos   = in_item.result_pixel > res_thr_q;
	assign tru_pos   = in_item.truth_pixel > tru_thr_q;

	always_comb begin
		cnt_inc = cnt_q;
		if (res_pos && tru_pos) begin
			cnt_inc.tp = bmcm_pkg::sat_bump(cnt_q.tp);
		end else if (!res_pos && !tru_pos) begin
			cnt_inc.tn = bmcm_pkg::sat_bump(cnt_q.tn);
		end else if (res_pos) begin
			cnt_inc.fp = bmcm_pkg::sat_bump(cnt_q.fp);
		end else begin
			cnt_inc.fn = bmcm_pkg::sat_bump(cnt_q.fn);
		end
	end

	// snapshot includes the last pixel itself
	assign q_push = accept && in_item.last_pixel;
	assign q_data = cnt_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_thr_q <= bmcm_pkg::RESULT_THR_RST;
			tru_thr_q <= bmcm_pkg::TRUTH_THR_RST;
		end else if (cfg_valid) begin
			if (cfg_index == bmcm_pkg::REG_RESULT_THR) begin
				res_thr_q <= cfg_data;
			end else if (cfg_index == bmcm_pkg::REG_TRUTH_THR) begin
				tru_thr_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (in_item.last_pixel) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_inc;
			end
		end
	end

endmodule

/* design/bmcm_queue.sv */
module bmcm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_push,
	input  bmcm_pkg::counts_t q_data,
	output logic              q_full,
	input  logic              q_pop,
	output bmcm_pkg::counts_t q_head,
	output logic              q_empty
);

	bmcm_pkg::counts_t                mem_q [bmcm_pkg::QDEPTH];
	logic [bmcm_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [bmcm_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [bmcm_pkg::QCNT_W-1:0]      count_q;
	logic                             do_push;
	logic                             do_pop;

	assign q_full  = count_q == bmcm_pkg::QCNT_W'(bmcm_pkg::QDEPTH);
	assign q_empty = count_q == '0;
	assign do_push = q_push && !q_full;
	assign do_pop  = q_pop && !q_empty;
	assign q_head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + bmcm_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + bmcm_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + bmcm_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - bmcm_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

/* design/bmcm_back.sv */
module bmcm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bmcm_pkg::counts_t   q_head,
	input  logic                q_empty,
	output logic                q_pop,
	output bmcm_pkg::out_item_t out_item,
	output logic                empty,
	input  logic                pop
);

	bmcm_pkg::back_state_t            state_q;
	bmcm_pkg::back_state_t            state_nxt;
	bmcm_pkg::rate_sel_t              sel_q;
	logic [bmcm_pkg::STEP_W-1:0]      step_q;
	logic [bmcm_pkg::SUM_W-1:0]       rem_q;
	logic [bmcm_pkg::RATE_W-1:0]      quo_q;
	logic [bmcm_pkg::RATE_W-1:0]      rate_q [bmcm_pkg::RATE_NUM];
	bmcm_pkg::out_item_t              out_q;
	logic                             out_valid_q;

	logic [bmcm_pkg::SUM_W-1:0]       num;
	logic [bmcm_pkg::SUM_W-1:0]       den;
	logic [bmcm_pkg::SUM_W:0]         trial;
	logic [bmcm_pkg::SUM_W:0]         diff;
	logic                             ge;
	logic [bmcm_pkg::SUM_W-1:0]       rem_nxt;
	logic [bmcm_pkg::RATE_W-1:0]      quo_nxt;
	logic                             step_last;
	logic                             div_run;
	logic                             load_out;
	logic                             out_free;

	logic [bmcm_pkg::SUM_W-1:0] tp_x, tn_x, fp_x, fn_x;

	assign tp_x = bmcm_pkg::SUM_W'(q_head.tp);
	assign tn_x = bmcm_pkg::SUM_W'(q_head.tn);
	assign fp_x = bmcm_pkg::SUM_W'(q_head.fp);
	assign fn_x = bmcm_pkg::SUM_W'(q_head.fn);

	always_comb begin
		case (sel_q)
			bmcm_pkg::R_SENS: begin num = tp_x;        den = tp_x + fn_x; end
			bmcm_pkg::R_SPEC: begin num = tn_x;        den = tn_x + fp_x; end
			bmcm_pkg::R_FPR:  begin num = fp_x;        den = tn_x + fp_x; end
			bmcm_pkg::R_FNR:  begin num = fn_x;        den = tp_x + fn_x; end
			bmcm_pkg::R_PPV:  begin num = tp_x;        den = tp_x + fp_x; end
			bmcm_pkg::R_NPV:  begin num = tn_x;        den = tn_x + fn_x; end
			bmcm_pkg::R_ACC:  begin num = tp_x + tn_x; den = tp_x + tn_x + fp_x + fn_x; end
			default:          begin num = '0;          den = '0;          end
		endcase
	end

	// one quotient bit per cycle, first bit is the integer part
	assign trial   = (step_q == '0) ? {1'b0, num} : {rem_q, 1'b0};
	assign ge      = trial >= {1'b0, den};
	assign diff    = trial - {1'b0, den};
	assign rem_nxt = ge ? diff[bmcm_pkg::SUM_W-1:0] : trial[bmcm_pkg::SUM_W-1:0];
	assign quo_nxt = {quo_q[bmcm_pkg::RATE_W-2:0], ge};
	assign step_last = step_q == bmcm_pkg::LAST_STEP;
	assign out_free  = !out_valid_q || pop;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			bmcm_pkg::BK_IDLE: begin
				if (!q_empty) begin
					state_nxt = bmcm_pkg::BK_DIV;
				end
			end
			bmcm_pkg::BK_DIV: begin
				if (step_last && sel_q == bmcm_pkg::R_ACC) begin
					state_nxt = bmcm_pkg::BK_OUT;
				end
			end
			bmcm_pkg::BK_OUT: begin
				if (out_free) begin
					state_nxt = bmcm_pkg::BK_IDLE;
				end
			end
			default: state_nxt = bmcm_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		div_run  = 1'b0;
		load_out = 1'b0;
		case (state_q)
			bmcm_pkg::BK_DIV: div_run  = 1'b1;
			bmcm_pkg::BK_OUT: load_out = out_free;
			default: begin
				div_run  = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	assign q_pop = load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bmcm_pkg::BK_IDLE;
			sel_q       <= bmcm_pkg::R_SENS;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (!div_run) begin
				sel_q  <= bmcm_pkg::R_SENS;
				step_q <= '0;
			end else if (step_last) begin
				sel_q  <= bmcm_pkg::rate_sel_t'(sel_q + 3'd1);
				step_q <= '0;
			end else begin
				step_q <= step_q + bmcm_pkg::STEP_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_run) begin
			rem_q <= rem_nxt;
			quo_q <= quo_nxt;
			if (step_last) begin
				rate_q[sel_q] <= (den == '0) ? '0 : quo_nxt;
			end
		end
		if (load_out) begin
			out_q.true_pos       <= q_head.tp;
			out_q.true_neg       <= q_head.tn;
			out_q.false_pos      <= q_head.fp;
			out_q.false_neg      <= q_head.fn;
			out_q.sensitivity    <= rate_q[bmcm_pkg::R_SENS];
			out_q.specificity    <= rate_q[bmcm_pkg::R_SPEC];
			out_q.false_pos_rate <= rate_q[bmcm_pkg::R_FPR];
			out_q.false_neg_rate <= rate_q[bmcm_pkg::R_FNR];
			out_q.pos_pred_value <= rate_q[bmcm_pkg::R_PPV];
			out_q.neg_pred_value <= rate_q[bmcm_pkg::R_NPV];
			out_q.accuracy       <= rate_q[bmcm_pkg::R_ACC];
		end
	end

	assign out_item = out_q;
	assign empty    = !out_valid_q;

endmodule

/* design/binary_mask_confusion_metrics_unit.sv */
// pixels: one transfer per cycle while not full, classified and counted in the cycle
// of the transfer; end of image: counts go to a two-entry queue; the back end runs one
// shared restoring divider that computes the seven rates one after another, while the
// front end already counts the next image
// reset: counters clear, thresholds load 0 and 3, queue and output register empty
module binary_mask_confusion_metrics_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  bmcm_pkg::in_item_t             in_item,
	output logic                           empty,
	input  logic                           pop,
	output bmcm_pkg::out_item_t            out_item,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bmcm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bmcm_pkg::PIX_W-1:0]     cfg_data
);

	logic              q_push;
	logic              q_full;
	logic              q_pop;
	logic              q_empty;
	bmcm_pkg::counts_t q_data;
	bmcm_pkg::counts_t q_head;

	assign full = q_full;

	bmcm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_item   (in_item),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bmcm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_push  (q_push),
		.q_data  (q_data),
		.q_full  (q_full),
		.q_pop   (q_pop),
		.q_head  (q_head),
		.q_empty (q_empty)
	);

	bmcm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_head   (q_head),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.out_item (out_item),
		.empty    (empty),
		.pop      (pop)
	);

	logic [bmcm_pkg::SUM_W-1:0]  total;
	logic [bmcm_pkg::RATE_W:0]   sens_fnr;

	assign total = bmcm_pkg::SUM_W'(out_item.true_pos) + bmcm_pkg::SUM_W'(out_item.true_neg)
		+ bmcm_pkg::SUM_W'(out_item.false_pos) + bmcm_pkg::SUM_W'(out_item.false_neg);
	assign sens_fnr = {1'b0, out_item.sensitivity} + {1'b0, out_item.false_neg_rate};

	// every image has at least its last pixel
	a_nonzero_total: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> total != '0)
		else $error("result with zero pixel total");

	// complementary floored rates sum to one or one lsb below, or both are zero
	a_sens_fnr: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (sens_fnr == '0 || sens_fnr == 18'd65535 || sens_fnr == 18'd65536))
		else $error("sensitivity and miss rate disagree");

	a_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (out_item.true_pos <= bmcm_pkg::MAX_PIXELS
			&& out_item.false_neg <= bmcm_pkg::MAX_PIXELS))
		else $error("count beyond saturation limit");

	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("count queue both full and empty");

endmodule
